// ----- rtl/s2l_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s2l_pkg: shared constants and helpers for the lunar date converter
// year table of packed month-length words, gregorian month tables and
// small residue helpers
// ----------------------------------------------------------------------------
package s2l_pkg;

  localparam int ROM_SIZE = 201;

  // bits 15..4 month 1..12 long, bits 3..0 leap month (0xf: none, prior leap long)
  localparam logic [15:0] YEAR_ROM [ROM_SIZE] = '{
    16'h4bd8, 16'h4ae0, 16'ha570, 16'h54d5, 16'hd260, 16'hd950, 16'h5554, 16'h56af,
    16'h9ad0, 16'h55d2, 16'h4ae0, 16'ha5b6, 16'ha4d0, 16'hd250, 16'hd255, 16'hb54f,
    16'hd6a0, 16'hada2, 16'h95b0, 16'h4977, 16'h497f, 16'ha4b0, 16'hb4b5, 16'h6a50,
    16'h6d40, 16'hab54, 16'h2b6f, 16'h9570, 16'h52f2, 16'h4970, 16'h6566, 16'hd4a0,
    16'hea50, 16'h6a95, 16'h5adf, 16'h2b60, 16'h86e3, 16'h92ef, 16'hc8d7, 16'hc95f,
    16'hd4a0, 16'hd8a6, 16'hb55f, 16'h56a0, 16'ha5b4, 16'h25df, 16'h92d0, 16'hd2b2,
    16'ha950, 16'hb557, 16'h6ca0, 16'hb550, 16'h5355, 16'h4daf, 16'ha5b0, 16'h4573,
    16'h52bf, 16'ha9a8, 16'he950, 16'h6aa0, 16'haea6, 16'hab50, 16'h4b60, 16'haae4,
    16'ha570, 16'h5260, 16'hf263, 16'hd950, 16'h5b57, 16'h56a0, 16'h96d0, 16'h4dd5,
    16'h4ad0, 16'ha4d0, 16'hd4d4, 16'hd250, 16'hd558, 16'hb540, 16'hb6a0, 16'h95a6,
    16'h95bf, 16'h49b0, 16'ha974, 16'ha4b0, 16'hb27a, 16'h6a50, 16'h6d40, 16'haf46,
    16'hab60, 16'h9570, 16'h4af5, 16'h4970, 16'h64b0, 16'h74a3, 16'hea50, 16'h6b58,
    16'h5ac0, 16'hab60, 16'h96d5, 16'h92e0, 16'hc960, 16'hd954, 16'hd4a0, 16'hda50,
    16'h7552, 16'h56a0, 16'habb7, 16'h25d0, 16'h92d0, 16'hcab5, 16'ha950, 16'hb4a0,
    16'hbaa4, 16'had50, 16'h55d9, 16'h4ba0, 16'ha5b0, 16'h5176, 16'h52bf, 16'ha930,
    16'h7954, 16'h6aa0, 16'had50, 16'h5b52, 16'h4b60, 16'ha6e6, 16'ha4e0, 16'hd260,
    16'hea65, 16'hd530, 16'h5aa0, 16'h76a3, 16'h96d0, 16'h4afb, 16'h4ad0, 16'ha4d0,
    16'hd0b6, 16'hd25f, 16'hd520, 16'hdd45, 16'hb5a0, 16'h56d0, 16'h55b2, 16'h49b0,
    16'ha577, 16'ha4b0, 16'haa50, 16'hb255, 16'h6d2f, 16'hada0, 16'h4b63, 16'h937f,
    16'h49f8, 16'h4970, 16'h64b0, 16'h68a6, 16'hea5f, 16'h6b20, 16'ha6c4, 16'haaef,
    16'h92e0, 16'hd2e3, 16'hc960, 16'hd557, 16'hd4a0, 16'hda50, 16'h5d55, 16'h56a0,
    16'ha6d0, 16'h55d4, 16'h52d0, 16'ha9b8, 16'ha950, 16'hb4a0, 16'hb6a6, 16'had50,
    16'h55a0, 16'haba4, 16'ha5b0, 16'h52b0, 16'hb273, 16'h6930, 16'h7337, 16'h6aa0,
    16'had50, 16'h4b55, 16'h4b6f, 16'ha570, 16'h54e4, 16'hd260, 16'he968, 16'hd520,
    16'hdaa0, 16'h6aa6, 16'h56df, 16'h4ae0, 16'ha9d4, 16'ha4d0, 16'hd150, 16'hf252,
    16'hd520
  };

  localparam logic [3:0] NO_LEAP_LONG = 4'hf;
  localparam logic [3:0] LAST_MONTH   = 4'd12;
  localparam logic [8:0] BASE_YEAR_DAYS = 9'd348;

  // year word, zero past the end of the table
  function automatic logic [15:0] rom_word(input logic [7:0] idx);
    logic [15:0] w;
    w = '0;
    if (idx < 8'(ROM_SIZE)) begin
      w = YEAR_ROM[idx];
    end
    return w;
  endfunction

  function automatic logic [3:0] popcnt12(input logic [11:0] v);
    logic [3:0] c;
    c = '0;
    for (int k = 0; k < 12; k++) begin
      c = c + 4'(v[k]);
    end
    return c;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] n;
    case (m)
      4'd2:                    n = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

  // residues of a value below 60
  function automatic logic [3:0] mod10_6(input logic [5:0] r);
    logic [5:0] v;
    v = r;
    for (int k = 0; k < 5; k++) begin
      if (v >= 6'd10) begin
        v = v - 6'd10;
      end
    end
    return v[3:0];
  endfunction

  function automatic logic [3:0] mod12_6(input logic [5:0] r);
    logic [5:0] v;
    v = r;
    for (int k = 0; k < 4; k++) begin
      if (v >= 6'd12) begin
        v = v - 6'd12;
      end
    end
    return v[3:0];
  endfunction

  function automatic logic [3:0] inc_mod10(input logic [3:0] v);
    return (v == 4'd9) ? 4'd0 : v + 4'd1;
  endfunction

  function automatic logic [3:0] inc_mod12(input logic [3:0] v);
    return (v == 4'd11) ? 4'd0 : v + 4'd1;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/s2l_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s2l_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module s2l_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 201
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- rtl/solar_to_lunar_date_converter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// solar_to_lunar_date_converter: gregorian date to chinese lunar date
// counts days from 1900-01-31, walks a ram of per-year lunar records one
// year per cycle, then the months of the found year one per cycle
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | in_tvalid / in_tready  | in_tdata 24b: gregorian year/month/day
//  out     | out_tvalid / out_tready| out_tdata 48b lunar date, out_tuser 1b
//
// after reset the year ram is filled from the constant table, one year per
// cycle; no word is taken meanwhile
// one date at a time: accept, the day count through the year / 100, day
// count, day cycle / 60 and residue states, the year walk over the ram,
// the month walk (at most 13 months), then the output state
// the output register lets the next date be taken while a result waits;
// a finished result stalls in the output state only while that register is full
// reset is synchronous, active low
//
module solar_to_lunar_date_converter #(
  parameter int TABLE_YEARS = 201
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // [11:0] solar_year, [15:12] solar_month, [20:16] solar_day, [23:21] zero
  input  wire logic [23:0] in_tdata,

  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // [11:0] lunar_year, [15:12] lunar_month, [20:16] lunar_day,
  // [21] is_leap_month, [22] month_is_long, [26:23] year_stem,
  // [30:27] year_branch, [34:31] month_stem, [38:35] month_branch,
  // [42:39] day_stem, [46:43] day_branch, [47] zero
  output      logic [47:0] out_tdata,
  // [0] date_invalid
  output      logic [0:0]  out_tuser
);

  localparam int AW    = $clog2(TABLE_YEARS);
  localparam int CW    = AW + 1;
  localparam int RAM_W = 26;                     // {year_len[8:0], leap_long, word[15:0]}
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_YEARS - 1);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,   // ram fill sweep
    S_IDLE  = 9'b000000010,
    S_DIV   = 9'b000000100,   // year / 100
    S_DAYS  = 9'b000001000,   // checks and day count
    S_D60   = 9'b000010000,   // day cycle / 60
    S_DREM  = 9'b000100000,   // day cycle residue, walk setup
    S_YEAR  = 9'b001000000,
    S_MONTH = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [11:0]   y_r, y_nxt;
  logic [3:0]    m_r, m_nxt;
  logic [4:0]    d_r, d_nxt;
  logic [5:0]    q100_r, q100_nxt;
  logic [19:0]   since_r, since_nxt;
  logic [14:0]   q60_r, q60_nxt;
  logic [19:0]   off_r, off_nxt;
  logic          inv_r, inv_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [3:0]    ys_r, ys_nxt, yb_r, yb_nxt, yms_r, yms_nxt;
  logic [3:0]    ms_r, ms_nxt, mb_r, mb_nxt;
  logic [3:0]    ds_r, ds_nxt, db_r, db_nxt;
  logic [15:0]   word_r, word_nxt;
  logic          lleap_r, lleap_nxt;
  logic [3:0]    mon_r, mon_nxt;
  logic          lstep_r, lstep_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [47:0]   out_tdata_r, out_tdata_nxt;
  logic          out_tuser_r, out_tuser_nxt;

  // ram fill: record of one year with its length precomputed
  logic [15:0]       fill_word, fill_next_word;
  logic [CW-1:0]     fill_next_idx;
  logic              fill_next_long;
  logic              fill_leap_ok;
  logic [8:0]        fill_ylen;
  logic [RAM_W-1:0]  wr_data, rd_data;
  logic [AW-1:0]     rd_addr;

  assign fill_word      = s2l_pkg::rom_word(8'(fill_cnt_r));
  assign fill_next_idx  = CW'(fill_cnt_r) + CW'(1);
  assign fill_next_word = s2l_pkg::rom_word(8'(fill_next_idx));
  assign fill_next_long = (fill_next_idx < CW'(TABLE_YEARS)) &&
                          (fill_next_word[3:0] == s2l_pkg::NO_LEAP_LONG);
  assign fill_leap_ok   = (fill_word[3:0] != 4'd0) &&
                          (fill_word[3:0] <= s2l_pkg::LAST_MONTH);
  assign fill_ylen      = s2l_pkg::BASE_YEAR_DAYS
                        + 9'(s2l_pkg::popcnt12(fill_word[15:4]))
                        + (fill_leap_ok ? (fill_next_long ? 9'd30 : 9'd29) : 9'd0);
  assign wr_data        = {fill_ylen, fill_next_long, fill_word};

  // year walk reads one record ahead; record 0 is read in the cycle before
  assign rd_addr = (state_r == S_YEAR && idx_r != LAST_IDX) ? idx_r + AW'(1) : '0;

  s2l_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_YEARS)
  ) u_year_ram (
    .clk     (clk),
    .wr_en   (state_r == S_INIT),
    .wr_addr (fill_cnt_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // gregorian day count from 1900-01-01
  logic [24:0] prod100;
  logic        y100_hit, greg_leap;
  logic [11:0] p_yr, n_yr;
  logic [9:0]  pd4;
  logic [5:0]  pd100;
  logic [3:0]  pd400;
  logic [10:0] leaps;
  logic [20:0] day_sum;
  logic [19:0] since_w;
  logic [4:0]  mlen;
  logic        greg_bad;

  assign prod100   = 25'(y_r) * 25'd5243;
  assign y100_hit  = (12'(q100_r) * 12'd100) == y_r;
  assign greg_leap = (y_r[1:0] == 2'd0) && (!y100_hit || q100_r[1:0] == 2'd0);
  assign p_yr      = y_r - 12'd1;
  assign n_yr      = y_r - 12'd1900;
  assign pd4       = p_yr[11:2];
  assign pd100     = y100_hit ? q100_r - 6'd1 : q100_r;
  assign pd400     = (y100_hit && q100_r[1:0] == 2'd0) ? q100_r[5:2] - 4'd1 : q100_r[5:2];
  assign leaps     = 11'(pd4) - 11'(pd100) + 11'(pd400);
  // 460 leap days lie before 1900
  assign day_sum   = 21'(n_yr) * 21'd365 + 21'(leaps) - 21'd460
                   + 21'(s2l_pkg::cum_days(m_r))
                   + ((greg_leap && m_r > 4'd2) ? 21'd1 : 21'd0)
                   + 21'(d_r) - 21'd1;
  assign since_w   = day_sum[19:0];
  assign mlen      = s2l_pkg::month_days(m_r)
                   + ((m_r == 4'd2 && greg_leap) ? 5'd1 : 5'd0);
  assign greg_bad  = (y_r < 12'd1900) || !(m_r inside {[4'd1:4'd12]}) ||
                     (d_r == 5'd0) || (d_r > mlen) || (since_w < 20'd30);

  // day cycle modulo 60 by reciprocal
  logic [19:0] dcyc;
  logic [36:0] prod60;
  logic [19:0] drem;

  assign dcyc   = since_r + 20'd10;
  assign prod60 = 37'(dcyc[19:2]) * 37'd279621;
  assign drem   = dcyc - 20'(q60_r) * 20'd60;

  // month walk
  logic [8:0] yr_len;
  logic [3:0] leap_mon, mbit;
  logic       cur_long;
  logic [4:0] cur_len;

  assign yr_len   = rd_data[25:17];
  assign leap_mon = (word_r[3:0] > s2l_pkg::LAST_MONTH) ? 4'd0 : word_r[3:0];
  assign mbit     = 4'(5'd16 - 5'(mon_r));
  assign cur_long = lstep_r ? lleap_r : word_r[mbit];
  assign cur_len  = cur_long ? 5'd30 : 5'd29;

  always_comb begin
    state_nxt      = state_r;
    fill_cnt_nxt   = fill_cnt_r;
    y_nxt          = y_r;
    m_nxt          = m_r;
    d_nxt          = d_r;
    q100_nxt       = q100_r;
    since_nxt      = since_r;
    q60_nxt        = q60_r;
    off_nxt        = off_r;
    inv_nxt        = inv_r;
    idx_nxt        = idx_r;
    ys_nxt         = ys_r;
    yb_nxt         = yb_r;
    yms_nxt        = yms_r;
    ms_nxt         = ms_r;
    mb_nxt         = mb_r;
    ds_nxt         = ds_r;
    db_nxt         = db_r;
    word_nxt       = word_r;
    lleap_nxt      = lleap_r;
    mon_nxt        = mon_r;
    lstep_nxt      = lstep_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    case (state_r)
      S_INIT: begin
        fill_cnt_nxt = fill_cnt_r + AW'(1);
        if (fill_cnt_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          y_nxt     = in_tdata[11:0];
          m_nxt     = in_tdata[15:12];
          d_nxt     = in_tdata[20:16];
          inv_nxt   = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        q100_nxt  = prod100[24:19];
        state_nxt = S_DAYS;
      end
      S_DAYS: begin
        since_nxt = since_w;
        off_nxt   = since_w - 20'd30;
        if (greg_bad) begin
          inv_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_D60;
        end
      end
      S_D60: begin
        q60_nxt   = prod60[36:22];
        state_nxt = S_DREM;
      end
      S_DREM: begin
        ds_nxt    = s2l_pkg::mod10_6(drem[5:0]);
        db_nxt    = s2l_pkg::mod12_6(drem[5:0]);
        idx_nxt   = '0;
        ys_nxt    = 4'd6;     // 36 mod 10
        yb_nxt    = 4'd0;     // 36 mod 12
        yms_nxt   = 4'd4;     // month 1 of year 0: 14 mod 10
        state_nxt = S_YEAR;
      end
      S_YEAR: begin
        if (off_r < 20'(yr_len)) begin
          word_nxt  = rd_data[15:0];
          lleap_nxt = rd_data[16];
          mon_nxt   = 4'd1;
          lstep_nxt = 1'b0;
          ms_nxt    = yms_r;
          mb_nxt    = 4'd2;   // 14 mod 12, same every year
          state_nxt = S_MONTH;
        end else begin
          off_nxt = off_r - 20'(yr_len);
          if (idx_r == LAST_IDX) begin
            inv_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else begin
            idx_nxt = idx_r + AW'(1);
            ys_nxt  = s2l_pkg::inc_mod10(ys_r);
            yb_nxt  = s2l_pkg::inc_mod12(yb_r);
            // twelve more months: stem moves by two
            yms_nxt = (yms_r >= 4'd8) ? yms_r - 4'd8 : yms_r + 4'd2;
          end
        end
      end
      S_MONTH: begin
        if (off_r < 20'(cur_len)) begin
          state_nxt = S_OUT;
        end else begin
          off_nxt = off_r - 20'(cur_len);
          if (!lstep_r && mon_r == leap_mon) begin
            lstep_nxt = 1'b1;
          end else if (mon_r == s2l_pkg::LAST_MONTH) begin
            inv_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else begin
            mon_nxt   = mon_r + 4'd1;
            lstep_nxt = 1'b0;
            ms_nxt    = s2l_pkg::inc_mod10(ms_r);
            mb_nxt    = s2l_pkg::inc_mod12(mb_r);
          end
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = inv_r;
          if (inv_r) begin
            out_tdata_nxt = '0;
          end else begin
            out_tdata_nxt = {1'b0, db_r, ds_r, mb_r, ms_r, yb_r, ys_r,
                             cur_long, lstep_r, off_r[4:0] + 5'd1, mon_r,
                             12'd1900 + 12'(idx_r)};
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      fill_cnt_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_cnt_r   <= fill_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    y_r         <= y_nxt;
    m_r         <= m_nxt;
    d_r         <= d_nxt;
    q100_r      <= q100_nxt;
    since_r     <= since_nxt;
    q60_r       <= q60_nxt;
    off_r       <= off_nxt;
    inv_r       <= inv_nxt;
    idx_r       <= idx_nxt;
    ys_r        <= ys_nxt;
    yb_r        <= yb_nxt;
    yms_r       <= yms_nxt;
    ms_r        <= ms_nxt;
    mb_r        <= mb_nxt;
    ds_r        <= ds_nxt;
    db_r        <= db_nxt;
    word_r      <= word_nxt;
    lleap_r     <= lleap_nxt;
    mon_r       <= mon_nxt;
    lstep_r     <= lstep_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  // a taken date blocks the input until its result is out
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a date is in progress");

  // the year walk never reads past the table
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_YEAR) |-> (idx_r <= LAST_IDX))
    else $error("year index beyond table");

  // the intercalary step only follows its own month
  a_leap_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MONTH && lstep_r) |-> (mon_r == leap_mon && leap_mon != 4'd0))
    else $error("leap step on wrong month");

  // a valid result has a lunar day 1..30 and month 1..12
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |->
      (out_tdata[20:16] != 5'd0 && out_tdata[20:16] <= 5'd30 &&
       out_tdata[15:12] != 4'd0 && out_tdata[15:12] <= 4'd12))
    else $error("lunar date out of range");

  // an invalid result carries an all-zero word
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == 48'd0))
    else $error("invalid result with nonzero payload");
`endif

endmodule
`default_nettype wire

// ----- tb/solar_to_lunar_date_converter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// solar_to_lunar_date_converter_tb: gregorian to lunar date converter check
// feeds directed edge dates and random dates through the stream ports under
// changing backpressure, predicts every lunar result from an independent copy
// of the year table and compares each returned word field by field
// ----------------------------------------------------------------------------
module solar_to_lunar_date_converter_tb;

  localparam int TABLE_YEARS  = 201;
  localparam int RANDOM_DATES = 1050;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int PHASE_WORDS  = 150;

  // per-year lunar month lengths, bits 15..4 months 1..12, bits 3..0 leap month
  localparam logic [15:0] YEAR_INFO [TABLE_YEARS] = '{
    16'h4bd8, 16'h4ae0, 16'ha570, 16'h54d5, 16'hd260, 16'hd950, 16'h5554, 16'h56af,
    16'h9ad0, 16'h55d2, 16'h4ae0, 16'ha5b6, 16'ha4d0, 16'hd250, 16'hd255, 16'hb54f,
    16'hd6a0, 16'hada2, 16'h95b0, 16'h4977, 16'h497f, 16'ha4b0, 16'hb4b5, 16'h6a50,
    16'h6d40, 16'hab54, 16'h2b6f, 16'h9570, 16'h52f2, 16'h4970, 16'h6566, 16'hd4a0,
    16'hea50, 16'h6a95, 16'h5adf, 16'h2b60, 16'h86e3, 16'h92ef, 16'hc8d7, 16'hc95f,
    16'hd4a0, 16'hd8a6, 16'hb55f, 16'h56a0, 16'ha5b4, 16'h25df, 16'h92d0, 16'hd2b2,
    16'ha950, 16'hb557, 16'h6ca0, 16'hb550, 16'h5355, 16'h4daf, 16'ha5b0, 16'h4573,
    16'h52bf, 16'ha9a8, 16'he950, 16'h6aa0, 16'haea6, 16'hab50, 16'h4b60, 16'haae4,
    16'ha570, 16'h5260, 16'hf263, 16'hd950, 16'h5b57, 16'h56a0, 16'h96d0, 16'h4dd5,
    16'h4ad0, 16'ha4d0, 16'hd4d4, 16'hd250, 16'hd558, 16'hb540, 16'hb6a0, 16'h95a6,
    16'h95bf, 16'h49b0, 16'ha974, 16'ha4b0, 16'hb27a, 16'h6a50, 16'h6d40, 16'haf46,
    16'hab60, 16'h9570, 16'h4af5, 16'h4970, 16'h64b0, 16'h74a3, 16'hea50, 16'h6b58,
    16'h5ac0, 16'hab60, 16'h96d5, 16'h92e0, 16'hc960, 16'hd954, 16'hd4a0, 16'hda50,
    16'h7552, 16'h56a0, 16'habb7, 16'h25d0, 16'h92d0, 16'hcab5, 16'ha950, 16'hb4a0,
    16'hbaa4, 16'had50, 16'h55d9, 16'h4ba0, 16'ha5b0, 16'h5176, 16'h52bf, 16'ha930,
    16'h7954, 16'h6aa0, 16'had50, 16'h5b52, 16'h4b60, 16'ha6e6, 16'ha4e0, 16'hd260,
    16'hea65, 16'hd530, 16'h5aa0, 16'h76a3, 16'h96d0, 16'h4afb, 16'h4ad0, 16'ha4d0,
    16'hd0b6, 16'hd25f, 16'hd520, 16'hdd45, 16'hb5a0, 16'h56d0, 16'h55b2, 16'h49b0,
    16'ha577, 16'ha4b0, 16'haa50, 16'hb255, 16'h6d2f, 16'hada0, 16'h4b63, 16'h937f,
    16'h49f8, 16'h4970, 16'h64b0, 16'h68a6, 16'hea5f, 16'h6b20, 16'ha6c4, 16'haaef,
    16'h92e0, 16'hd2e3, 16'hc960, 16'hd557, 16'hd4a0, 16'hda50, 16'h5d55, 16'h56a0,
    16'ha6d0, 16'h55d4, 16'h52d0, 16'ha9b8, 16'ha950, 16'hb4a0, 16'hb6a6, 16'had50,
    16'h55a0, 16'haba4, 16'ha5b0, 16'h52b0, 16'hb273, 16'h6930, 16'h7337, 16'h6aa0,
    16'had50, 16'h4b55, 16'h4b6f, 16'ha570, 16'h54e4, 16'hd260, 16'he968, 16'hd520,
    16'hdaa0, 16'h6aa6, 16'h56df, 16'h4ae0, 16'ha9d4, 16'ha4d0, 16'hd150, 16'hf252,
    16'hd520
  };

  localparam logic [3:0]  LONG_PRIOR_LEAP = 4'hf;  // no leap here, prior leap is long
  localparam int unsigned FIRST_YEAR      = 1900;
  localparam int unsigned LUNAR_EPOCH_DAY = 30;    // 1900-01-31 is lunar new year

  localparam int unsigned CUM_DAYS [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  localparam int unsigned GREG_MONTH_DAYS [12] =
    '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // input word, first field in the low bits
  typedef struct packed {
    logic [2:0]  pad;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } solar_date_t;

  // output word, same layout as out_tdata
  typedef struct packed {
    logic        pad;
    logic [3:0]  day_branch;
    logic [3:0]  day_stem;
    logic [3:0]  month_branch;
    logic [3:0]  month_stem;
    logic [3:0]  year_branch;
    logic [3:0]  year_stem;
    logic        month_is_long;
    logic        is_leap_month;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } lunar_fields_t;

  typedef struct {
    logic          invalid;
    lunar_fields_t f;
  } lunar_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [0:0]  out_tuser;

  solar_date_t   solar_dates_q [$];   // dates waiting to be driven
  lunar_result_t lunar_dates_due [$]; // predicted results, oldest first

  int unsigned accepted_count = 0;
  int unsigned result_count   = 0;
  int unsigned invalid_count  = 0;
  int unsigned leap_count     = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned idle_phase;

  solar_to_lunar_date_converter #(
    .TABLE_YEARS(TABLE_YEARS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] year_info_word(input int unsigned idx);
    return (idx < TABLE_YEARS) ? YEAR_INFO[idx] : 16'h0000;
  endfunction

  // leap nibbles above 12 mean no leap month
  function automatic int unsigned leap_month_of(input int unsigned idx);
    int unsigned lm;
    lm = year_info_word(idx) & 16'h000f;
    return (lm > 12) ? 0 : lm;
  endfunction

  // the following year's nibble decides the leap month length
  function automatic int unsigned leap_month_days(input int unsigned idx);
    logic [15:0] w;
    if (leap_month_of(idx) == 0) begin
      return 0;
    end
    w = year_info_word(idx + 1);
    return (w[3:0] == LONG_PRIOR_LEAP) ? 30 : 29;
  endfunction

  function automatic int unsigned lunar_month_days(input int unsigned idx,
                                                   input int unsigned mon);
    logic [15:0] w;
    w = year_info_word(idx);
    return w[16 - mon] ? 30 : 29;
  endfunction

  function automatic int unsigned lunar_year_days(input int unsigned idx);
    logic [15:0] w;
    w = year_info_word(idx);
    return 348 + $countones(w[15:4]) + leap_month_days(idx);
  endfunction

  function automatic bit is_greg_leap(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_greg_month(input int unsigned y,
                                                     input int unsigned m);
    return GREG_MONTH_DAYS[m - 1] + ((m == 2 && is_greg_leap(y)) ? 1 : 0);
  endfunction

  function automatic int unsigned days_before_greg_year(input int unsigned y);
    int unsigned p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic lunar_result_t lunar_from_solar(input solar_date_t s);
    lunar_result_t r;
    int unsigned   y, m, d, since, off, idx, lm, mon, len, cyc;
    bit            found, in_leap;
    r.invalid = 1'b1;
    r.f = '0;
    y = s.year;
    m = s.month;
    d = s.day;
    if (y < FIRST_YEAR || m < 1 || m > 12 || d < 1) begin
      return r;
    end
    if (d > days_in_greg_month(y, m)) begin
      return r;
    end
    since = days_before_greg_year(y) - days_before_greg_year(FIRST_YEAR) + CUM_DAYS[m - 1]
          + ((is_greg_leap(y) && m > 2) ? 1 : 0) + d - 1;
    if (since < LUNAR_EPOCH_DAY) begin
      return r;
    end
    off = since - LUNAR_EPOCH_DAY;

    // whole lunar years first
    idx = 0;
    while (idx < TABLE_YEARS && off >= lunar_year_days(idx)) begin
      off -= lunar_year_days(idx);
      idx++;
    end
    if (idx >= TABLE_YEARS) begin
      return r;
    end

    // then months, the leap month sits right after the month it follows
    lm = leap_month_of(idx);
    found = 1'b0;
    in_leap = 1'b0;
    mon = 1;
    len = 0;
    while (!found && mon <= 12) begin
      len = lunar_month_days(idx, mon);
      if (off < len) begin
        found = 1'b1;
      end else begin
        off -= len;
        if (mon == lm) begin
          len = leap_month_days(idx);
          if (off < len) begin
            found = 1'b1;
            in_leap = 1'b1;
          end else begin
            off -= len;
          end
        end
      end
      if (!found) begin
        mon++;
      end
    end
    if (!found) begin
      return r;
    end

    r.invalid         = 1'b0;
    r.f.year          = 12'(FIRST_YEAR + idx);
    r.f.month         = 4'(mon);
    r.f.day           = 5'(off + 1);
    r.f.is_leap_month = in_leap;
    r.f.month_is_long = (len > 29);
    cyc = idx + 36;
    r.f.year_stem     = 4'(cyc % 10);
    r.f.year_branch   = 4'(cyc % 12);
    cyc = idx * 12 + mon + 13;
    r.f.month_stem    = 4'(cyc % 10);
    r.f.month_branch  = 4'(cyc % 12);
    cyc = since + 10;
    r.f.day_stem      = 4'(cyc % 10);
    r.f.day_branch    = 4'(cyc % 12);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic solar_date_t make_date(input int unsigned y, input int unsigned m,
                                            input int unsigned d);
    solar_date_t s;
    s.pad   = '0;
    s.year  = 12'(y);
    s.month = 4'(m);
    s.day   = 5'(d);
    return s;
  endfunction

  function automatic solar_date_t random_date();
    int unsigned pick, y, m, d, mlen;
    pick = $urandom_range(99);
    y = $urandom_range(2101, 1900);
    m = $urandom_range(12, 1);
    if (pick < 60) begin
      // well-formed date anywhere in the table span
      d = $urandom_range(days_in_greg_month(y, m), 1);
    end else if (pick < 72) begin
      // near the ends of the table: first lunar new year and the last years
      if (pick < 66) begin
        y = FIRST_YEAR;
        m = $urandom_range(3, 1);
      end else begin
        y = $urandom_range(2102, 2100);
      end
      d = $urandom_range(days_in_greg_month(y, m), 1);
    end else if (pick < 84) begin
      // broken gregorian date: bad month, day zero or day past month end
      mlen = days_in_greg_month(y, m);
      case ($urandom_range(2))
        0: begin
          m = $urandom_range(1) ? 0 : $urandom_range(15, 13);
          d = $urandom_range(31, 1);
        end
        1: d = 0;
        default: d = (mlen == 31) ? 0 : $urandom_range(31, mlen + 1);
      endcase
    end else begin
      // raw field noise
      y = $urandom_range(4095);
      m = $urandom_range(15);
      d = $urandom_range(31);
    end
    return make_date(y, m, d);
  endfunction

  // ---------------------------------------------------------------- idling

  // cycles through no idling, sender gaps, receiver stalls and both
  always_comb begin
    idle_phase    = (accepted_count / PHASE_WORDS) % 4;
    in_idle_pct   = (idle_phase == 1) ? 56 : (idle_phase == 3) ? 22 : 0;
    out_stall_pct = (idle_phase == 2) ? 56 : (idle_phase == 3) ? 22 : 0;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        lunar_dates_due.push_back(lunar_from_solar(in_tdata));
        accepted_count++;
      end
      // load the next word once the current one is taken or none is up
      if (!in_tvalid || in_tready) begin
        if (solar_dates_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          in_tdata  <= solar_dates_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch in result %0d, %s: expected %0d, got %0d",
                 result_count, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    lunar_result_t want;
    lunar_fields_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        result_count++;
        if (lunar_dates_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result %0d: invalid %0d, word %h",
                     result_count, out_tuser[0], out_tdata);
          end
        end else begin
          want = lunar_dates_due.pop_front();
          if (want.invalid) begin
            invalid_count++;
          end
          if (want.f.is_leap_month) begin
            leap_count++;
          end
          check_field("date_invalid", want.invalid, out_tuser[0]);
          check_field("lunar_year", want.f.year, got.year);
          check_field("lunar_month", want.f.month, got.month);
          check_field("lunar_day", want.f.day, got.day);
          check_field("is_leap_month", want.f.is_leap_month, got.is_leap_month);
          check_field("month_is_long", want.f.month_is_long, got.month_is_long);
          check_field("year_stem", want.f.year_stem, got.year_stem);
          check_field("year_branch", want.f.year_branch, got.year_branch);
          check_field("month_stem", want.f.month_stem, got.month_stem);
          check_field("month_branch", want.f.month_branch, got.month_branch);
          check_field("day_stem", want.f.day_stem, got.day_stem);
          check_field("day_branch", want.f.day_branch, got.day_branch);
          check_field("reserved bit", 0, got.pad);
        end
      end
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d dates taken, %0d results pending",
               cycle_count, accepted_count, lunar_dates_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // directed edge dates
    solar_dates_q.push_back(make_date(1900, 1, 1));    // before lunar 1900
    solar_dates_q.push_back(make_date(1900, 1, 30));   // last day before it
    solar_dates_q.push_back(make_date(1900, 1, 31));   // first lunar day
    solar_dates_q.push_back(make_date(1900, 2, 19));
    solar_dates_q.push_back(make_date(1899, 12, 31));  // year below range
    solar_dates_q.push_back(make_date(0, 0, 0));       // all fields zero
    solar_dates_q.push_back(make_date(4095, 15, 31));  // all fields ones
    solar_dates_q.push_back(make_date(4095, 12, 31));  // far past the table
    solar_dates_q.push_back(make_date(1900, 2, 29));   // century, not leap
    solar_dates_q.push_back(make_date(2000, 2, 29));   // 400-year leap day
    solar_dates_q.push_back(make_date(2100, 2, 29));
    solar_dates_q.push_back(make_date(2024, 2, 30));
    solar_dates_q.push_back(make_date(2023, 4, 31));
    solar_dates_q.push_back(make_date(2023, 0, 10));
    solar_dates_q.push_back(make_date(2023, 13, 1));
    solar_dates_q.push_back(make_date(2023, 6, 0));
    solar_dates_q.push_back(make_date(2023, 3, 22));   // start of a leap month
    solar_dates_q.push_back(make_date(1906, 6, 20));   // 30-day leap month
    solar_dates_q.push_back(make_date(1984, 2, 2));
    solar_dates_q.push_back(make_date(2099, 12, 31));
    solar_dates_q.push_back(make_date(2100, 12, 31));
    solar_dates_q.push_back(make_date(2101, 1, 1));    // last table year
    solar_dates_q.push_back(make_date(2101, 1, 28));
    solar_dates_q.push_back(make_date(2101, 1, 31));   // around the table end
    solar_dates_q.push_back(make_date(2101, 12, 31));  // past the table
    for (int i = 0; i < RANDOM_DATES; i++) begin
      solar_dates_q.push_back(random_date());
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // drain: every date taken and every result back
    while (solar_dates_q.size() > 0 || in_tvalid || lunar_dates_due.size() > 0) begin
      @(posedge clk);
    end
    repeat (TABLE_YEARS + 40) @(posedge clk);

    $display("%0d dates converted, %0d flagged invalid, %0d in leap months",
             result_count, invalid_count, leap_count);
    $display("backpressure phases: none, sender gaps, receiver stalls, both; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && lunar_dates_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
